// ===== design/crdg_pkg.sv =====
// shared constants and types for the camera ray direction generator
// no dependencies, compiled first
package crdg_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int JIT_W          = 16;
	localparam int BASIS_W        = 16;
	localparam int WIDTH_W        = 13;
	localparam int DEN_W          = WIDTH_W + 1;
	localparam int PIX_SHIFT      = 17;
	localparam int HALF_Q16       = 32768;
	localparam int ONE_Q16        = 65536;
	localparam int VIEW_SHIFT     = 16;
	localparam int NORM_W         = 30;
	localparam int NORM_TOP       = NORM_W - 1;
	localparam int SUM_W          = 2 * NORM_W + 2;
	localparam int ROOT_W         = SUM_W / 2;
	localparam int OUT_FRAC       = 14;
	localparam int OUT_W          = 16;
	localparam int OUT_ONE        = 16384;
	localparam int LQ_W           = OUT_FRAC + 1;
	localparam int LN_W           = NORM_W + LQ_W;
	localparam int REG_IDX_W      = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RIGHT_X     = 3'd0,
		REG_UP_Y        = 3'd1,
		REG_UP_Z        = 3'd2,
		REG_VIEW_X      = 3'd3,
		REG_VIEW_Y      = 3'd4,
		REG_VIEW_Z      = 3'd5,
		REG_IMAGE_WIDTH = 3'd6
	} cfg_reg_t;

	localparam logic signed [BASIS_W-1:0] RST_RIGHT_X = 16'sd4096;
	localparam logic signed [BASIS_W-1:0] RST_VIEW_Z  = -16'sd4096;
	localparam logic [WIDTH_W-1:0]        RST_WIDTH   = 13'd512;

endpackage

// ===== design/crdg_if.sv =====
// valid/ready channels of the ray generator: pixel items, ray items, config writes
// depends on crdg_pkg
interface crdg_in_if #(parameter int COORD_BITS = crdg_pkg::COORD_BITS_DEF);
	import crdg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_col;
	logic [COORD_BITS-1:0] pixel_row;
	logic [JIT_W-1:0]      jitter_x;
	logic [JIT_W-1:0]      jitter_y;
	modport source (output valid, pixel_col, pixel_row, jitter_x, jitter_y, input ready);
	modport sink (input valid, pixel_col, pixel_row, jitter_x, jitter_y, output ready);
endinterface

interface crdg_out_if;
	import crdg_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] ray_dx;
	logic signed [OUT_W-1:0] ray_dy;
	logic signed [OUT_W-1:0] ray_dz;
	modport source (output valid, ray_dx, ray_dy, ray_dz, input ready);
	modport sink (input valid, ray_dx, ray_dy, ray_dz, output ready);
endinterface

interface crdg_cfg_if;
	import crdg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [BASIS_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/crdg_delay.sv =====
// stall-aware delay line for side data that rides along a pipelined unit
// no package dependency
module crdg_delay #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] stage_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				stage_q[k] <= stage_q[k-1];
			end
		end
	end

	assign q = stage_q[DEPTH-1];
endmodule

// ===== design/crdg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
// needs num < den * 2^Q_W; no package dependency
module crdg_div #(
	parameter int LANES = 2,
	parameter int NUM_W = 31,
	parameter int DEN_W = 14,
	parameter int Q_W   = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num [LANES],
	input  logic [DEN_W-1:0] in_den,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quo [LANES]
);
	logic [Q_W-1:0]   v_q;
	logic [Q_W-1:0]   v_nx;
	logic [DEN_W-1:0] den_q  [Q_W];
	logic [DEN_W-1:0] den_nx [Q_W];
	logic [DEN_W-1:0] rem_q  [Q_W][LANES];
	logic [DEN_W-1:0] rem_nx [Q_W][LANES];
	// partial dividend bits shift out at the top, quotient bits shift in below
	logic [Q_W-1:0]   x_q    [Q_W][LANES];
	logic [Q_W-1:0]   x_nx   [Q_W][LANES];

	always_comb begin
		logic [DEN_W-1:0] r;
		logic [Q_W-1:0]   x;
		logic [DEN_W-1:0] d;
		logic [DEN_W:0]   t;
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				d       = in_den;
				v_nx[k] = in_valid;
			end else begin
				d       = den_q[k-1];
				v_nx[k] = v_q[k-1];
			end
			den_nx[k] = d;
			for (int l = 0; l < LANES; l++) begin
				if (k == 0) begin
					r = DEN_W'(in_num[l] >> Q_W);
					x = in_num[l][Q_W-1:0];
				end else begin
					r = rem_q[k-1][l];
					x = x_q[k-1][l];
				end
				t = {r, x[Q_W-1]};
				if (t >= {1'b0, d}) begin
					rem_nx[k][l] = DEN_W'(t - {1'b0, d});
					x_nx[k][l]   = {x[Q_W-2:0], 1'b1};
				end else begin
					rem_nx[k][l] = t[DEN_W-1:0];
					x_nx[k][l]   = {x[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= v_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_nx;
			rem_q <= rem_nx;
			x_q   <= x_nx;
		end
	end

	assign out_valid = v_q[Q_W-1];
	assign out_quo   = x_q[Q_W-1];
endmodule

// ===== design/crdg_isqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on crdg_pkg for the sum and root widths
module crdg_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [crdg_pkg::SUM_W-1:0]  in_sum,
	output logic                        out_valid,
	output logic [crdg_pkg::ROOT_W-1:0] out_root
);
	import crdg_pkg::*;

	logic [ROOT_W-1:0] v_q;
	logic [ROOT_W-1:0] v_nx;
	logic [SUM_W-1:0]  s_q  [ROOT_W];
	logic [SUM_W-1:0]  s_nx [ROOT_W];
	logic [SUM_W-1:0]  r_q  [ROOT_W];
	logic [SUM_W-1:0]  r_nx [ROOT_W];

	always_comb begin
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] trial;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				s       = in_sum;
				r       = '0;
				v_nx[k] = in_valid;
			end else begin
				s       = s_q[k-1];
				r       = r_q[k-1];
				v_nx[k] = v_q[k-1];
			end
			b     = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
			trial = r + b;
			if (s >= trial) begin
				s_nx[k] = s - trial;
				r_nx[k] = (r >> 1) + b;
			end else begin
				s_nx[k] = s;
				r_nx[k] = r >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= v_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= s_nx;
			r_q <= r_nx;
		end
	end

	assign out_valid = v_q[ROOT_W-1];
	assign out_root  = r_q[ROOT_W-1][ROOT_W-1:0];
endmodule

// ===== design/camera_ray_direction_gen.sv =====
// top level: pinhole camera primary ray direction generator
// depends on crdg_pkg, crdg_if, crdg_delay, crdg_div, crdg_isqrt
//
//  port  role     carries
//  ----  -------  -----------------------------------------------------
//  req   sink     pixel item: pixel_col, pixel_row, jitter_x, jitter_y
//  ray   source   ray item: ray_dx, ray_dy, ray_dz (q1.14)
//  cfg   sink     register write: index, data (always ready)
//
// one item per cycle sustained while ray.ready holds; the bulk of the pipe is the pipelined
// screen divider, the 31-stage square root and the 15-stage length divider
// arst_n clears all valid bits and loads the register reset values
// a stall on ray freezes the whole pipe through one enable; nothing is dropped
module camera_ray_direction_gen #(
	parameter int COORD_BITS = crdg_pkg::COORD_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	crdg_in_if.sink  req,
	crdg_out_if.source ray,
	crdg_cfg_if.sink cfg
);
	import crdg_pkg::*;

	// screen numerator width, covers the pixel term and the width offset
	localparam int CB_TOP     = (COORD_BITS + PIX_SHIFT > 29) ? COORD_BITS + PIX_SHIFT : 29;
	localparam int SN_W       = CB_TOP + 2;
	localparam int SQ_W       = SN_W - 1;
	localparam int P_W        = SN_W + BASIS_W;
	localparam int D_W        = P_W + 1;
	localparam int POS_W      = $clog2(D_W);
	localparam int ISQ_SIDE_W = 1 + 3 + 3 * NORM_W;
	localparam int LD_SIDE_W  = 1 + 3;
	localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(OUT_ONE);
	localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX;

	// camera registers
	logic signed [BASIS_W-1:0] right_x_q, up_y_q, up_z_q;
	logic signed [BASIS_W-1:0] view_x_q, view_y_q, view_z_q;
	logic [WIDTH_W-1:0]        width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_x_q <= RST_RIGHT_X;
			up_y_q    <= '0;
			up_z_q    <= '0;
			view_x_q  <= '0;
			view_y_q  <= '0;
			view_z_q  <= RST_VIEW_Z;
			width_q   <= RST_WIDTH;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_RIGHT_X:     right_x_q <= cfg.data;
				REG_UP_Y:        up_y_q    <= cfg.data;
				REG_UP_Z:        up_z_q    <= cfg.data;
				REG_VIEW_X:      view_x_q  <= cfg.data;
				REG_VIEW_Y:      view_y_q  <= cfg.data;
				REG_VIEW_Z:      view_z_q  <= cfg.data;
				REG_IMAGE_WIDTH: width_q   <= cfg.data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero width counts as one
	logic [WIDTH_W-1:0] w_eff;
	logic [DEN_W-1:0]   den_scr;
	logic [SN_W-1:0]    w_off;

	assign w_eff   = (width_q == '0) ? WIDTH_W'(1) : width_q;
	assign den_scr = {w_eff, 1'b0};
	// w * (2^16 + 1): rounding term plus a bias that keeps the dividend positive
	assign w_off   = (SN_W'(w_eff) << 16) + SN_W'(w_eff);

	// global advance: last stage empty or being taken
	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || ray.ready;
	assign req.ready = adv;

	// stage 1: screen dividends
	// x centre is 0 and y centre is 0.5, the jitter maps f to (f - 0.5) / 2 on x and to (f + 0.5) / 2 on y
	logic            v_s1;
	logic [SN_W-1:0] numx_s1, numy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			numx_s1 <= (SN_W'(req.pixel_col) << PIX_SHIFT) + SN_W'(req.jitter_x) + w_off
				- SN_W'(HALF_Q16);
			numy_s1 <= (SN_W'(req.pixel_row) << PIX_SHIFT) + SN_W'(req.jitter_y) + w_off
				+ SN_W'(HALF_Q16);
		end
	end

	// screen divide by 2w, both axes
	logic [SN_W-1:0] scr_num [2];
	logic            v_scr;
	logic [SQ_W-1:0] scr_quo [2];

	assign scr_num[0] = numx_s1;
	assign scr_num[1] = numy_s1;

	crdg_div #(
		.LANES (2),
		.NUM_W (SN_W),
		.DEN_W (DEN_W),
		.Q_W   (SQ_W)
	) u_scr_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_num    (scr_num),
		.in_den    (den_scr),
		.out_valid (v_scr),
		.out_quo   (scr_quo)
	);

	// remove the bias: quotient carries 2^15 from the offset and 2^15 of the centering
	logic signed [SN_W-1:0]    sx_c, sy_c;
	logic signed [SN_W-1:0]    scr_c   [3];
	logic signed [BASIS_W-1:0] basis_c [3];
	logic signed [BASIS_W-1:0] view_c  [3];

	assign sx_c = $signed({1'b0, scr_quo[0]}) - $signed(SN_W'(ONE_Q16));
	assign sy_c = $signed({1'b0, scr_quo[1]}) - $signed(SN_W'(ONE_Q16));

	assign scr_c[0]   = sx_c;
	assign scr_c[1]   = sy_c;
	assign scr_c[2]   = sy_c;
	assign basis_c[0] = right_x_q;
	assign basis_c[1] = up_y_q;
	assign basis_c[2] = up_z_q;
	assign view_c[0]  = view_x_q;
	assign view_c[1]  = view_y_q;
	assign view_c[2]  = view_z_q;

	// stage 2: basis weighting
	logic                  v_s2;
	logic signed [P_W-1:0] p_s2 [3];

	// stage 3: add the view term
	logic                  v_s3;
	logic signed [D_W-1:0] d_s3 [3];

	// stage 4: magnitudes, signs, or of magnitudes for the leading one
	logic           v_s4;
	logic [D_W-1:0] a_s4 [3];
	logic [2:0]     sgn_s4;
	logic [D_W-1:0] m_s4;
	logic [D_W-1:0] mag_c [3];

	// stage 5: leading one position
	logic             v_s5;
	logic [D_W-1:0]   a_s5 [3];
	logic [2:0]       sgn_s5;
	logic [POS_W-1:0] pos_s5;
	logic             zero_s5;
	logic [POS_W-1:0] pos_c;

	// stage 6: normalize so the largest lies in [2^29, 2^30)
	logic              v_s6;
	logic [NORM_W-1:0] an_s6 [3];
	logic [2:0]        sgn_s6;
	logic              zero_s6;

	// stage 7: squares
	logic                v_s7;
	logic [2*NORM_W-1:0] sq_s7 [3];
	logic [NORM_W-1:0]   an_s7 [3];
	logic [2:0]          sgn_s7;
	logic                zero_s7;

	// stage 8: sum of squares
	logic              v_s8;
	logic [SUM_W-1:0]  sum_s8;
	logic [NORM_W-1:0] an_s8 [3];
	logic [2:0]        sgn_s8;
	logic              zero_s8;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_c[k] = d_s3[k][D_W-1] ? D_W'(-d_s3[k]) : D_W'(d_s3[k]);
		end
	end

	// priority encoder, highest set bit wins
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < D_W; i++) begin
			if (m_s4[i]) begin
				pos_c = POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_scr;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				p_s2[k] <= basis_c[k] * scr_c[k];
				d_s3[k] <= (D_W'(view_c[k]) <<< VIEW_SHIFT) + D_W'(p_s2[k]);
				a_s4[k] <= mag_c[k];
				sgn_s4[k] <= d_s3[k][D_W-1];
				a_s5[k] <= a_s4[k];
				if (pos_s5 >= POS_W'(NORM_TOP)) begin
					an_s6[k] <= NORM_W'(a_s5[k] >> (pos_s5 - POS_W'(NORM_TOP)));
				end else begin
					an_s6[k] <= NORM_W'(a_s5[k] << (POS_W'(NORM_TOP) - pos_s5));
				end
				sq_s7[k] <= an_s6[k] * an_s6[k];
				an_s7[k] <= an_s6[k];
				an_s8[k] <= an_s7[k];
			end
			m_s4    <= mag_c[0] | mag_c[1] | mag_c[2];
			sgn_s5  <= sgn_s4;
			pos_s5  <= pos_c;
			zero_s5 <= (m_s4 == '0);
			sgn_s6  <= sgn_s5;
			zero_s6 <= zero_s5;
			sgn_s7  <= sgn_s6;
			zero_s7 <= zero_s6;
			sum_s8  <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
			sgn_s8  <= sgn_s7;
			zero_s8 <= zero_s7;
		end
	end

	// vector length
	logic                  v_rt;
	logic [ROOT_W-1:0]     root_rt;
	logic [ISQ_SIDE_W-1:0] isq_side_in, isq_side_out;
	logic [NORM_W-1:0]     an_rt [3];
	logic [2:0]            sgn_rt;
	logic                  zero_rt;

	crdg_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.in_sum    (sum_s8),
		.out_valid (v_rt),
		.out_root  (root_rt)
	);

	assign isq_side_in = {zero_s8, sgn_s8, an_s8[2], an_s8[1], an_s8[0]};

	crdg_delay #(
		.WIDTH (ISQ_SIDE_W),
		.DEPTH (ROOT_W)
	) u_isq_side (
		.clk (clk),
		.en  (adv),
		.d   (isq_side_in),
		.q   (isq_side_out)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			an_rt[k] = isq_side_out[k*NORM_W +: NORM_W];
		end
	end
	assign sgn_rt  = isq_side_out[ISQ_SIDE_W-2 -: 3];
	assign zero_rt = isq_side_out[ISQ_SIDE_W-1];

	// stage 9: rounded dividends a * 2^14 + len / 2
	logic              v_s9;
	logic [LN_W-1:0]   lnum_s9 [3];
	logic [ROOT_W-1:0] lden_s9;
	logic [2:0]        sgn_s9;
	logic              zero_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				lnum_s9[k] <= (LN_W'(an_rt[k]) << OUT_FRAC) + LN_W'(root_rt >> 1);
			end
			lden_s9 <= root_rt;
			sgn_s9  <= sgn_rt;
			zero_s9 <= zero_rt;
		end
	end

	// divide each component by the length
	logic                 v_ld;
	logic [LQ_W-1:0]      quo_ld [3];
	logic [LD_SIDE_W-1:0] ld_side_in, ld_side_out;
	logic [2:0]           sgn_ld;
	logic                 zero_ld;

	crdg_div #(
		.LANES (3),
		.NUM_W (LN_W),
		.DEN_W (ROOT_W),
		.Q_W   (LQ_W)
	) u_len_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.in_num    (lnum_s9),
		.in_den    (lden_s9),
		.out_valid (v_ld),
		.out_quo   (quo_ld)
	);

	assign ld_side_in = {zero_s9, sgn_s9};

	crdg_delay #(
		.WIDTH (LD_SIDE_W),
		.DEPTH (LQ_W)
	) u_ld_side (
		.clk (clk),
		.en  (adv),
		.d   (ld_side_in),
		.q   (ld_side_out)
	);

	assign sgn_ld  = ld_side_out[2:0];
	assign zero_ld = ld_side_out[LD_SIDE_W-1];

	// output register: sign applied, degenerate direction gives zero
	logic signed [OUT_W-1:0] rd_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_ld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				if (zero_ld) begin
					rd_q[k] <= '0;
				end else if (sgn_ld[k]) begin
					rd_q[k] <= -OUT_W'(quo_ld[k]);
				end else begin
					rd_q[k] <= OUT_W'(quo_ld[k]);
				end
			end
		end
	end

	assign ray.valid  = out_valid_q;
	assign ray.ray_dx = rd_q[0];
	assign ray.ray_dy = rd_q[1];
	assign ray.ray_dz = rd_q[2];

	// checks
	logic [NORM_W-1:0] norm_or;
	assign norm_or = an_s6[0] | an_s6[1] | an_s6[2];

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !zero_s6 |-> norm_or[NORM_TOP])
		else $error("normalized largest component misses the top bit");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_rt && !zero_rt |-> root_rt[ROOT_W-1:ROOT_W-2] != 2'b00)
		else $error("vector length below normalized range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> rd_q[0] <= OUT_MAX && rd_q[0] >= OUT_MIN
			&& rd_q[1] <= OUT_MAX && rd_q[1] >= OUT_MIN
			&& rd_q[2] <= OUT_MAX && rd_q[2] >= OUT_MIN)
		else $error("ray component outside unit range");
endmodule
